// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, skipped while reset is low.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rci_pkg.sv
// ----------------------------------------------------------------------------
// rci_pkg
// Types, widths and small helpers for the ray versus double cone intersector.
// ----------------------------------------------------------------------------
package rci_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int SUM_W         = 68;   // exact a, h, c sums before the shift
    localparam int COEF_W        = 64;   // floored a, h, c
    localparam int DISC_W        = 130;  // h*h - a*c, exact
    localparam int ROOT_W        = 64;   // isqrt result
    localparam int NUM_W         = 66;   // -h -/+ s
    localparam int QUO_W         = 128;  // quotient bits before saturation
    localparam int YACC_W        = 100;

    typedef struct packed {
        logic signed [WORD_W-1:0] origin_x;
        logic signed [WORD_W-1:0] origin_y;
        logic signed [WORD_W-1:0] origin_z;
        logic signed [WORD_W-1:0] dir_x;
        logic signed [WORD_W-1:0] dir_y;
        logic signed [WORD_W-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic                     near_valid;
        logic signed [WORD_W-1:0] near_t;
        logic                     far_valid;
        logic signed [WORD_W-1:0] far_t;
    } hit_t;

    // Saturate a signed quotient held as sign plus magnitude.
    function automatic logic signed [WORD_W-1:0] sat_quo(
        input logic negative, input logic [QUO_W-1:0] q);
        logic signed [WORD_W-1:0] r;
        begin
            r = '0;
            if (negative)
            begin
                if (q >= QUO_W'(64'h8000_0000))
                    r = {1'b1, {(WORD_W-1){1'b0}}};
                else
                    r = WORD_W'(-$signed({1'b0, q[WORD_W-1:0]}));
            end
            else
            begin
                if (q > QUO_W'(64'h7FFF_FFFF))
                    r = {1'b0, {(WORD_W-1){1'b1}}};
                else
                    r = q[WORD_W-1:0];
            end
            sat_quo = r;
        end
    endfunction

endpackage

// File: design/rci_cell.sv
// ----------------------------------------------------------------------------
// rci_cell
// One carrier cell of a solver row. Holds the side data that travels with a
// ray and hands it to the next cell whenever the row advances.
// ----------------------------------------------------------------------------
module rci_cell #(
    parameter int W = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d_in,
    output logic [W-1:0] d_out
);
    logic [W-1:0] d_reg;

    // advance with the row, hold otherwise
    always_ff @(posedge clk)
    begin
        if (en)
            d_reg <= d_in;
    end
    assign d_out = d_reg;
endmodule

// File: design/rci_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rci_sqrt_cell
// One restoring square-root step: try one root bit, keep it if it fits.
// ----------------------------------------------------------------------------
module rci_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [rci_pkg::DISC_W-1:0]   rem_in,
    input  logic [rci_pkg::ROOT_W-1:0]   root_in,
    output logic [rci_pkg::DISC_W-1:0]   rem_out,
    output logic [rci_pkg::ROOT_W-1:0]   root_out
);
    import rci_pkg::*;
    // rem = disc - root^2; trial = (2*root + 2^BIT) * 2^BIT
    logic [DISC_W-1:0] trial;
    logic [DISC_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;

    assign trial = ((DISC_W'(root_in) << 1) | (DISC_W'(1) << BIT)) << BIT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rem_in >= trial)
            begin
                rem_reg  <= rem_in - trial;
                root_reg <= root_in | (ROOT_W'(1) << BIT);
            end
            else
            begin
                rem_reg  <= rem_in;
                root_reg <= root_in;
            end
        end
    end
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

// File: design/rci_div_cell.sv
// ----------------------------------------------------------------------------
// rci_div_cell
// One restoring divide step for both roots against the same divisor.
// ----------------------------------------------------------------------------
module rci_div_cell (
    input  logic                         clk,
    input  logic                         en,
    input  logic                         bit0_in,
    input  logic                         bit1_in,
    input  logic [rci_pkg::COEF_W-1:0]   d_in,
    input  logic [rci_pkg::COEF_W:0]     r0_in,
    input  logic [rci_pkg::COEF_W:0]     r1_in,
    input  logic [rci_pkg::QUO_W-1:0]    q0_in,
    input  logic [rci_pkg::QUO_W-1:0]    q1_in,
    output logic [rci_pkg::COEF_W:0]     r0_out,
    output logic [rci_pkg::COEF_W:0]     r1_out,
    output logic [rci_pkg::QUO_W-1:0]    q0_out,
    output logic [rci_pkg::QUO_W-1:0]    q1_out
);
    import rci_pkg::*;
    logic [COEF_W:0] s0, s1;
    logic [COEF_W:0] r0_reg, r1_reg;
    logic [QUO_W-1:0] q0_reg, q1_reg;

    // remainder stays below d, so the shifted value fits in COEF_W+1 bits
    assign s0 = {r0_in[COEF_W-1:0], bit0_in};
    assign s1 = {r1_in[COEF_W-1:0], bit1_in};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s0 >= {1'b0, d_in})
            begin
                r0_reg <= s0 - {1'b0, d_in};
                q0_reg <= {q0_in[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r0_reg <= s0;
                q0_reg <= {q0_in[QUO_W-2:0], 1'b0};
            end
            if (s1 >= {1'b0, d_in})
            begin
                r1_reg <= s1 - {1'b0, d_in};
                q1_reg <= {q1_in[QUO_W-2:0], 1'b1};
            end
            else
            begin
                r1_reg <= s1;
                q1_reg <= {q1_in[QUO_W-2:0], 1'b0};
            end
        end
    end
    assign r0_out = r0_reg;
    assign r1_out = r1_reg;
    assign q0_out = q0_reg;
    assign q1_out = q1_reg;
endmodule

// File: design/ray_cone_intersect.sv
// ----------------------------------------------------------------------------
// ray_cone_intersect
// Ray versus unit double cone x^2 - y^2 + z^2 = 0, truncated to -1 < y < 1.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake          | Word
// in      | input     | in_valid/in_stall  | rci_pkg::ray_t
// out     | output    | out_valid/out_stall| rci_pkg::hit_t
//
// One ray enters per cycle while the output does not stall. The pipeline is a
// front end of 8 stages, a row of 64 square-root cells, a negate stage, a row
// of 66+FRAC_BITS divide cells, and 3 stages for sort, y check and output;
// the rows set the depth.
// Reset clears only the valid bits of the pipeline.
// A stall at the output while out_valid is high freezes the whole pipeline; the output register holds.
// ----------------------------------------------------------------------------
module ray_cone_intersect #(
    parameter int FRAC_BITS = rci_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  rci_pkg::ray_t in_word,
    output logic          out_valid,
    input  logic          out_stall,
    output rci_pkg::hit_t out_word
);
    import rci_pkg::*;

    localparam int NSQ   = ROOT_W;
    localparam int NDV   = NUM_W + FRAC_BITS;
    localparam int DEPTH = 8 + NSQ + 1 + NDV + 3;

    // Global enable: the pipeline advances whenever the output can move.
    logic adv;
    logic [DEPTH-1:0] vld_reg;
    assign adv      = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // ---------------- front end: products, sums, discriminant -------------
    typedef logic signed [63:0] p64_t;
    ray_t r1_reg;
    p64_t pxx_reg, pyy_reg, pzz_reg, qxx_reg, qyy_reg, qzz_reg, oxx_reg, oyy_reg, ozz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg  <= in_word;
            pxx_reg <= in_word.dir_x * in_word.dir_x;
            pyy_reg <= in_word.dir_y * in_word.dir_y;
            pzz_reg <= in_word.dir_z * in_word.dir_z;
            qxx_reg <= in_word.origin_x * in_word.dir_x;
            qyy_reg <= in_word.origin_y * in_word.dir_y;
            qzz_reg <= in_word.origin_z * in_word.dir_z;
            oxx_reg <= in_word.origin_x * in_word.origin_x;
            oyy_reg <= in_word.origin_y * in_word.origin_y;
            ozz_reg <= in_word.origin_z * in_word.origin_z;
        end
    end

    ray_t r2_reg;
    logic signed [COEF_W-1:0] a2_reg, h2_reg, c2_reg;
    logic signed [SUM_W-1:0] sa, sh, sc;
    assign sa = SUM_W'(pxx_reg) - SUM_W'(pyy_reg) + SUM_W'(pzz_reg);
    assign sh = SUM_W'(qxx_reg) - SUM_W'(qyy_reg) + SUM_W'(qzz_reg);
    assign sc = SUM_W'(oxx_reg) - SUM_W'(oyy_reg) + SUM_W'(ozz_reg);
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r2_reg <= r1_reg;
            a2_reg <= COEF_W'(sa >>> FRAC_BITS);
            h2_reg <= COEF_W'(sh >>> FRAC_BITS);
            c2_reg <= COEF_W'(sc >>> FRAC_BITS);
        end
    end

    // 64x64 signed products cut into four 32x32 partial products.
    logic [63:0] hm, am, cm;
    logic        ac_neg;
    assign hm = h2_reg[63] ? 64'(-h2_reg) : 64'(h2_reg);
    assign am = a2_reg[63] ? 64'(-a2_reg) : 64'(a2_reg);
    assign cm = c2_reg[63] ? 64'(-c2_reg) : 64'(c2_reg);
    assign ac_neg = a2_reg[63] ^ c2_reg[63];

    ray_t r3_reg;
    logic signed [COEF_W-1:0] a3_reg, h3_reg;
    logic ac3_neg_reg;
    logic [63:0] hp_reg [4];
    logic [63:0] ap_reg [4];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r3_reg <= r2_reg;
            a3_reg <= a2_reg;
            h3_reg <= h2_reg;
            ac3_neg_reg <= ac_neg;
            hp_reg[0] <= hm[31:0]  * hm[31:0];
            hp_reg[1] <= hm[31:0]  * hm[63:32];
            hp_reg[2] <= hm[63:32] * hm[31:0];
            hp_reg[3] <= hm[63:32] * hm[63:32];
            ap_reg[0] <= am[31:0]  * cm[31:0];
            ap_reg[1] <= am[31:0]  * cm[63:32];
            ap_reg[2] <= am[63:32] * cm[31:0];
            ap_reg[3] <= am[63:32] * cm[63:32];
        end
    end

    ray_t r4_reg;
    logic signed [COEF_W-1:0] a4_reg, h4_reg;
    logic ac4_neg_reg;
    logic [127:0] hh4_reg, ac4_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r4_reg <= r3_reg;
            a4_reg <= a3_reg;
            h4_reg <= h3_reg;
            ac4_neg_reg <= ac3_neg_reg;
            hh4_reg <= 128'(hp_reg[0]) + (128'(hp_reg[1]) << 32)
                     + (128'(hp_reg[2]) << 32) + (128'(hp_reg[3]) << 64);
            ac4_reg <= 128'(ap_reg[0]) + (128'(ap_reg[1]) << 32)
                     + (128'(ap_reg[2]) << 32) + (128'(ap_reg[3]) << 64);
        end
    end

    ray_t r5_reg;
    logic signed [COEF_W-1:0] a5_reg, h5_reg;
    logic signed [DISC_W-1:0] disc5_reg;
    logic signed [DISC_W-1:0] acs;
    assign acs = ac4_neg_reg ? -$signed({2'b00, ac4_reg}) : $signed({2'b00, ac4_reg});
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r5_reg <= r4_reg;
            a5_reg <= a4_reg;
            h5_reg <= h4_reg;
            disc5_reg <= $signed({2'b00, hh4_reg}) - acs;
        end
    end

    // Stages 6..8: carry control and decide the miss flag before the rows.
    ray_t r8_reg;
    logic signed [COEF_W-1:0] a8_reg, h8_reg;
    logic [DISC_W-1:0] disc8_reg;
    logic miss8_reg;
    ray_t r6_reg, r7_reg;
    logic signed [COEF_W-1:0] a6_reg, h6_reg, a7_reg, h7_reg;
    logic [DISC_W-1:0] disc6_reg, disc7_reg;
    logic miss6_reg, miss7_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r6_reg <= r5_reg;  a6_reg <= a5_reg;  h6_reg <= h5_reg;
            miss6_reg <= disc5_reg[DISC_W-1] || (a5_reg == '0);
            disc6_reg <= disc5_reg[DISC_W-1] ? '0 : disc5_reg;
            r7_reg <= r6_reg;  a7_reg <= a6_reg;  h7_reg <= h6_reg;
            miss7_reg <= miss6_reg; disc7_reg <= disc6_reg;
            r8_reg <= r7_reg;  a8_reg <= a7_reg;  h8_reg <= h7_reg;
            miss8_reg <= miss7_reg; disc8_reg <= disc7_reg;
        end
    end

    // ---------------- square-root row -------------------------------------
    // Cells only advance with adv; side data rides along in carrier cells.
    typedef struct packed {
        ray_t                     ray;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] h;
        logic                     miss;
    } sq_side_t;

    logic [DISC_W-1:0] sq_rem  [NSQ+1];
    logic [ROOT_W-1:0] sq_root [NSQ+1];
    sq_side_t          sq_side [NSQ+1];
    assign sq_rem[0]  = disc8_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = '{ray: r8_reg, a: a8_reg, h: h8_reg, miss: miss8_reg};

    genvar gi;
    generate
        for (gi = 0; gi < NSQ; gi++)
        begin : g_sq
            rci_sqrt_cell #(
                .BIT (NSQ-1-gi)
            ) u_step (
                .clk      (clk),
                .en       (adv),
                .rem_in   (sq_rem[gi]),
                .root_in  (sq_root[gi]),
                .rem_out  (sq_rem[gi+1]),
                .root_out (sq_root[gi+1])
            );
            rci_cell #(
                .W ($bits(sq_side_t))
            ) u_side (
                .clk   (clk),
                .en    (adv),
                .d_in  (sq_side[gi]),
                .d_out (sq_side[gi+1])
            );
        end
    endgenerate

    // ---------------- numerators ------------------------------------------
    ray_t dv_ray0_reg;
    logic dv_miss0_reg;
    logic [COEF_W-1:0] dv_d0_reg;
    logic dv_neg0_reg, dv_neg1_reg;
    logic [NUM_W-1:0] n0m_reg, n1m_reg;
    logic signed [NUM_W-1:0] n0, n1;
    logic signed [COEF_W-1:0] af;
    sq_side_t sq_end;
    assign sq_end = sq_side[NSQ];
    assign af = sq_end.a;
    assign n0 = -NUM_W'(sq_end.h) - $signed(NUM_W'(sq_root[NSQ]));
    assign n1 = -NUM_W'(sq_end.h) + $signed(NUM_W'(sq_root[NSQ]));
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_ray0_reg  <= sq_end.ray;
            dv_miss0_reg <= sq_end.miss;
            dv_d0_reg    <= af[COEF_W-1] ? COEF_W'(-af) : COEF_W'(af);
            dv_neg0_reg  <= n0[NUM_W-1] ^ af[COEF_W-1];
            dv_neg1_reg  <= n1[NUM_W-1] ^ af[COEF_W-1];
            n0m_reg      <= n0[NUM_W-1] ? NUM_W'(-n0) : NUM_W'(n0);
            n1m_reg      <= n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
        end
    end

    // ---------------- divide row ------------------------------------------
    // Dividend = n * 2^F; each cell takes its own bit from the top down.
    // Leading quotient bits above the fed ones are zero and saturation uses
    // the rest.
    localparam int DVD_W = NUM_W + FRAC_BITS;
    logic [DVD_W-1:0] dvd0, dvd1;
    assign dvd0 = DVD_W'(n0m_reg) << FRAC_BITS;
    assign dvd1 = DVD_W'(n1m_reg) << FRAC_BITS;

    typedef struct packed {
        logic [DVD_W-1:0]  dvd0;
        logic [DVD_W-1:0]  dvd1;
        logic [COEF_W-1:0] d;
        ray_t              ray;
        logic              miss;
        logic              neg0;
        logic              neg1;
    } dv_side_t;

    logic [COEF_W:0]    dr0 [DVD_W+1];
    logic [COEF_W:0]    dr1 [DVD_W+1];
    logic [QUO_W-1:0]   dq0 [DVD_W+1];
    logic [QUO_W-1:0]   dq1 [DVD_W+1];
    dv_side_t           dside [DVD_W+1];
    assign dr0[0] = '0;  assign dr1[0] = '0;
    assign dq0[0] = '0;  assign dq1[0] = '0;
    assign dside[0] = '{dvd0: dvd0, dvd1: dvd1, d: dv_d0_reg, ray: dv_ray0_reg,
                        miss: dv_miss0_reg, neg0: dv_neg0_reg, neg1: dv_neg1_reg};

    generate
        for (gi = 0; gi < DVD_W; gi++)
        begin : g_dv
            rci_div_cell u_step (
                .clk     (clk),
                .en      (adv),
                .bit0_in (dside[gi].dvd0[DVD_W-1-gi]),
                .bit1_in (dside[gi].dvd1[DVD_W-1-gi]),
                .d_in    (dside[gi].d),
                .r0_in   (dr0[gi]),
                .r1_in   (dr1[gi]),
                .q0_in   (dq0[gi]),
                .q1_in   (dq1[gi]),
                .r0_out  (dr0[gi+1]),
                .r1_out  (dr1[gi+1]),
                .q0_out  (dq0[gi+1]),
                .q1_out  (dq1[gi+1])
            );
            rci_cell #(
                .W ($bits(dv_side_t))
            ) u_side (
                .clk   (clk),
                .en    (adv),
                .d_in  (dside[gi]),
                .d_out (dside[gi+1])
            );
        end
    endgenerate

    // ---------------- saturate, order, y check ----------------------------
    dv_side_t dv_end;
    assign dv_end = dside[DVD_W];

    logic signed [WORD_W-1:0] t0s, t1s;
    assign t0s = sat_quo(dv_end.neg0, dq0[DVD_W]);
    assign t1s = sat_quo(dv_end.neg1, dq1[DVD_W]);

    ray_t o1_ray_reg;
    logic o1_miss_reg;
    logic signed [WORD_W-1:0] tn_reg, tf_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o1_ray_reg  <= dv_end.ray;
            o1_miss_reg <= dv_end.miss;
            tn_reg <= (t0s > t1s) ? t1s : t0s;
            tf_reg <= (t0s > t1s) ? t0s : t1s;
        end
    end

    // t * dy as a full 64-bit signed product
    logic signed [63:0] pn, pf;
    assign pn = tn_reg * o1_ray_reg.dir_y;
    assign pf = tf_reg * o1_ray_reg.dir_y;

    logic signed [YACC_W-1:0] yb_reg, yn_reg, yf_reg;
    logic o2_miss_reg;
    logic signed [WORD_W-1:0] tn2_reg, tf2_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yb_reg  <= YACC_W'(o1_ray_reg.origin_y) <<< FRAC_BITS;
            yn_reg  <= YACC_W'(pn);
            yf_reg  <= YACC_W'(pf);
            o2_miss_reg <= o1_miss_reg;
            tn2_reg <= tn_reg;
            tf2_reg <= tf_reg;
        end
    end

    logic signed [YACC_W-1:0] one2, yn, yf;
    assign one2 = YACC_W'(1) <<< (2 * FRAC_BITS);
    assign yn = yb_reg + yn_reg;
    assign yf = yb_reg + yf_reg;

    hit_t out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (o2_miss_reg)
                out_reg <= '0;
            else
            begin
                out_reg.near_valid <= (yn > -one2) && (yn < one2);
                out_reg.near_t     <= tn2_reg;
                out_reg.far_valid  <= (yf > -one2) && (yf < one2);
                out_reg.far_t      <= tf2_reg;
            end
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_word  = out_reg;
endmodule

// File: design/ray_cone_intersect_chk.sv
// ----------------------------------------------------------------------------
// ray_cone_intersect_chk
// Port-level checks on the intersector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_cone_intersect_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          in_stall,
    input logic          out_valid,
    input logic          out_stall,
    input rci_pkg::hit_t out_word
);
    import rci_pkg::*;

    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "output word changed while stalled")
    `CHK_IMPLY(a_in_free, clk, rst_n, !out_valid, !in_stall, "input stalled with empty output")
    `CHK_IMPLY(a_order, clk, rst_n, out_valid && out_word.near_valid && out_word.far_valid, out_word.near_t <= out_word.far_t, "roots out of order")
    `CHK_IMPLY(a_stall_link, clk, rst_n, in_stall, out_valid && out_stall, "input stall without output stall")
endmodule

bind ray_cone_intersect ray_cone_intersect_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

// File: verif/ray_cone_intersect_tb.sv
// ----------------------------------------------------------------------------
// ray_cone_intersect_tb
// Self-checking bench for the ray versus truncated double cone intersector.
// Rays go in from a queue, in bursts and gaps. Each accepted ray is scored
// against a bit-true fixed-point model. The output side stalls on a
// pattern of its own, with one long hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module ray_cone_intersect_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rci_pkg::*;

    localparam int FB         = FRAC_BITS_DEF;
    localparam int ONE        = 1 << FB;
    localparam int N_RANDOM   = 1500;
    localparam int PAUSE_AT   = 800;      // sender drains the pipe here once
    localparam int HOLD_AT    = 300;      // long output hold-off starts here
    localparam int HOLD_LEN   = 400;
    localparam int TAIL_WAIT  = 400;      // margin after the last expected hit
    localparam int CYCLE_MAX  = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    ray_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    hit_t out_word;

    ray_t ray_q[$];       // rays still to be driven
    hit_t hit_q[$];       // expected hits, oldest first

    logic ray_took = 1'b0;
    logic stim_done = 1'b0;
    int   rays_driven = 0;
    int   rays_taken = 0;
    int   gap_left = 0;
    int   burst_left = 1;
    logic drained_once = 1'b0;
    int   hold_left = 0;
    logic held_once = 1'b0;
    int   stall_mode = 0;
    int   mode_left = 0;
    int   mismatch_cnt = 0;
    int   cycle_cnt = 0;

    ray_cone_intersect uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always #5 clk = ~clk;

    // n * 2^F / d, truncated toward zero, then clamped to 32 bits.
    function automatic logic signed [31:0] root_quotient(
        input logic signed [127:0] n, input logic signed [127:0] d);
        logic [127:0] mag_n;
        logic [127:0] mag_d;
        logic [127:0] q;
        logic         negative;
        begin
            negative = (n < 0) != (d < 0);
            mag_n = (n < 0) ? -n : n;
            mag_d = (d < 0) ? -d : d;
            q = (mag_n << FB) / mag_d;
            if (negative)
                root_quotient = (q >= 128'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
            else
                root_quotient = (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
        end
    endfunction

    // True when oy + t*dy lies strictly inside (-1, 1).
    function automatic logic y_in_band(
        input logic signed [127:0] oy, input logic signed [127:0] dy,
        input logic signed [31:0] t);
        logic signed [127:0] tw;
        logic signed [127:0] yv;
        logic signed [127:0] one2;
        begin
            tw = t;
            one2 = 128'sd1 <<< (2 * FB);
            yv = oy * ONE + tw * dy;
            y_in_band = (yv > -one2) && (yv < one2);
        end
    endfunction

    // Bit-true cone hit for one ray.
    function automatic hit_t cone_hit(input ray_t r);
        logic signed [127:0] ox, oy, oz, dx, dy, dz;
        logic signed [127:0] a, h, c, disc, s;
        logic [127:0]        cand;
        logic signed [31:0]  t0, t1, tmp;
        hit_t                res;
        begin
            res = '0;
            ox = $signed(r.origin_x);
            oy = $signed(r.origin_y);
            oz = $signed(r.origin_z);
            dx = $signed(r.dir_x);
            dy = $signed(r.dir_y);
            dz = $signed(r.dir_z);
            a = (dx * dx - dy * dy + dz * dz) >>> FB;
            h = (ox * dx - oy * dy + oz * dz) >>> FB;
            c = (ox * ox - oy * oy + oz * oz) >>> FB;
            disc = h * h - a * c;
            // parallel ray or missed cone: report nothing
            if (disc < 0 || a == 0)
                return res;
            s = 0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = s | (128'd1 << b);
                if (cand * cand <= disc)
                    s = cand;
            end
            t0 = root_quotient(-h - s, a);
            t1 = root_quotient(-h + s, a);
            if (t0 > t1)
            begin
                tmp = t0;
                t0 = t1;
                t1 = tmp;
            end
            res.near_valid = y_in_band(oy, dy, t0);
            res.near_t     = t0;
            res.far_valid  = y_in_band(oy, dy, t1);
            res.far_t      = t1;
            return res;
        end
    endfunction

    function automatic ray_t mk_ray(input int ox, oy, oz, dx, dy, dz);
        ray_t r;
        begin
            r.origin_x = ox;
            r.origin_y = oy;
            r.origin_z = oz;
            r.dir_x = dx;
            r.dir_y = dy;
            r.dir_z = dz;
            return r;
        end
    endfunction

    // Small coordinate within about +/-4.0 so rays actually meet the cone.
    function automatic int near_coord();
        return int'($urandom_range(0, 1 << (FB + 3))) - (1 << (FB + 2));
    endfunction

    // Fill the ray queue: directed corners first, then random rays.
    initial
    begin
        ray_t r;
        int   kind;
        // all zero: a is zero
        ray_q.push_back(mk_ray(0, 0, 0, 0, 0, 0));
        // direction on the cone surface: a is zero
        ray_q.push_back(mk_ray(ONE, 0, ONE / 2, ONE, ONE, 0));
        // negative discriminant: straight along x, offset in z
        ray_q.push_back(mk_ray(0, 0, ONE, ONE, 0, 0));
        // along y through x = 0.5, both roots inside the band
        ray_q.push_back(mk_ray(ONE / 2, 0, 0, 0, ONE, 0));
        // along x at y = 5, both roots outside the band
        ray_q.push_back(mk_ray(0, 5 * ONE, 0, ONE, 0, 0));
        // along x at y = 0.5
        ray_q.push_back(mk_ray(-3 * ONE, ONE / 2, 0, ONE, 0, 0));
        // through the apex
        ray_q.push_back(mk_ray(-2 * ONE, 0, 0, ONE, 0, 0));
        // direction of one lsb: a floors to zero, so the ray reports no hit
        ray_q.push_back(mk_ray(ONE, ONE / 2, 0, 1, 0, 0));
        ray_q.push_back(mk_ray(ONE, ONE / 2, 0, -1, 0, 0));
        ray_q.push_back(mk_ray(0, ONE / 2, 0, 0, 1, 1));
        // field extremes
        ray_q.push_back(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        ray_q.push_back(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        ray_q.push_back(mk_ray(32'h8000_0000, 0, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, 1, 32'h8000_0000));
        ray_q.push_back(mk_ray(0, 32'h7FFF_FFFF, 0, 1, 32'h8000_0000, -1));
        ray_q.push_back(mk_ray(-1, -1, -1, -1, -1, -1));
        ray_q.push_back(mk_ray(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
                r = mk_ray(near_coord(), near_coord(), near_coord(),
                           near_coord(), near_coord(), near_coord());
            else if (kind < 8)
            begin
                // direction on the cone surface, sometimes nudged by one lsb
                r = mk_ray(near_coord(), near_coord(), near_coord(),
                           near_coord(), 0, 0);
                r.dir_y = r.dir_x + int'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1))
                    r.dir_y = -r.dir_y;
            end
            else
                r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            ray_q.push_back(r);
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Sender: drive words at the falling edge, in bursts and gaps.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !ray_took)
            begin
                // hold the stalled word
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (rays_driven == PAUSE_AT && !drained_once)
            begin
                // wait until every expected hit has come back
                in_valid <= 1'b0;
                if (hit_q.size() == 0)
                    drained_once <= 1'b1;
            end
            else if (ray_q.size() > 0)
            begin
                in_word <= ray_q.pop_front();
                in_valid <= 1'b1;
                rays_driven <= rays_driven + 1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
            begin
                in_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // Receiver: stall pattern that changes mode every so often,
    // plus one long hold-off while the sender keeps offering rays.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!held_once && rays_taken >= HOLD_AT)
            begin
                held_once <= 1'b1;
                hold_left <= HOLD_LEN;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 3);
                    mode_left <= $urandom_range(20, 120);
                end
                else
                    mode_left <= mode_left - 1;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= cycle_cnt[2];
                endcase
            end
        end
    end

    // Score: predict on input acceptance, compare on output acceptance.
    always @(posedge clk)
    begin
        hit_t want;
        cycle_cnt <= cycle_cnt + 1;
        ray_took <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            hit_q.push_back(cone_hit(in_word));
            rays_taken <= rays_taken + 1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (hit_q.size() == 0)
            begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10)
                    $display("unexpected hit word %h", out_word);
            end
            else
            begin
                want = hit_q.pop_front();
                if (out_word.near_valid !== want.near_valid
                    || out_word.near_t !== want.near_t
                    || out_word.far_valid !== want.far_valid
                    || out_word.far_t !== want.far_t)
                begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("hit mismatch: want near %b %h far %b %h, got near %b %h far %b %h",
                                 want.near_valid, want.near_t, want.far_valid, want.far_t,
                                 out_word.near_valid, out_word.near_t,
                                 out_word.far_valid, out_word.far_t);
                end
            end
        end
    end

    // Finish once every ray is in and every hit has drained.
    initial
    begin
        @(posedge rst_n);
        while (!(stim_done && hit_q.size() == 0))
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatch_cnt == 0 && hit_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (cycle_cnt >= CYCLE_MAX)
        begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
